@@ src/dft_direct_forward_inverse_top_assert.svh @@
// Assertion macros for the DFT block.
`ifndef DFT_DIRECT_FORWARD_INVERSE_TOP_ASSERT_SVH
`define DFT_DIRECT_FORWARD_INVERSE_TOP_ASSERT_SVH
`ifndef SYNTH
`define DFT_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define DFT_ASSERT_NXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define DFT_ASSERT_IMP(label, a, c)
`define DFT_ASSERT_NXT(label, a, c)
`endif
`endif

@@ src/dft_pkg.sv @@
package dft_pkg;
  localparam int MaxPoints = 64;
  localparam int SampleW = 16;
  localparam int BinW = 24;
  localparam int IdxW = 6;
  localparam int AccW = 48;

  typedef struct packed {
    logic inverse;
  } dft_job_t;

  function automatic logic signed [16:0] quarter_sin(input logic [4:0] r);
    logic signed [16:0] v;
    v = '0;
    case (r)
      5'd0: v = 17'sd0;
      5'd1: v = 17'sd3212;
      5'd2: v = 17'sd6393;
      5'd3: v = 17'sd9512;
      5'd4: v = 17'sd12540;
      5'd5: v = 17'sd15447;
      5'd6: v = 17'sd18205;
      5'd7: v = 17'sd20788;
      5'd8: v = 17'sd23170;
      5'd9: v = 17'sd25330;
      5'd10: v = 17'sd27246;
      5'd11: v = 17'sd28899;
      5'd12: v = 17'sd30274;
      5'd13: v = 17'sd31357;
      5'd14: v = 17'sd32138;
      5'd15: v = 17'sd32610;
      5'd16: v = 17'sd32767;
      default: v = 17'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [16:0] rom_sin(input logic [5:0] m);
    logic [4:0] r;
    logic [4:0] rr;
    r = {1'b0, m[3:0]};
    rr = 5'd16 - r;
    case (m[5:4])
      2'd0: return quarter_sin(r);
      2'd1: return quarter_sin(rr);
      2'd2: return -quarter_sin(r);
      default: return -quarter_sin(rr);
    endcase
  endfunction
endpackage

@@ src/dft_front.sv @@
module dft_front #(
  parameter int POINTS = dft_pkg::MaxPoints,
  parameter int AW = $clog2(POINTS)
) (
  input  logic clk,
  input  logic rst,
  input  logic s_valid,
  output logic s_ready,
  input  logic [31:0] s_data,
  input  logic inverse_mode,
  output logic mem_we,
  output logic [AW-1:0] mem_addr,
  output logic [31:0] mem_data,
  output logic job_push,
  output dft_pkg::dft_job_t job,
  input  logic job_full
);
  import dft_pkg::*;

  logic [AW-1:0] load_count;
  logic take;

  assign s_ready = !job_full;
  assign take = s_valid && s_ready;
  assign mem_we = take;
  assign mem_addr = load_count;
  assign mem_data = s_data;
  assign job_push = take && (load_count == AW'(POINTS - 1));
  assign job.inverse = inverse_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else if (take) begin
      load_count <= load_count + AW'(1);
    end
  end
endmodule

@@ src/dft_back.sv @@
module dft_back #(
  parameter int POINTS = dft_pkg::MaxPoints,
  parameter int AW = $clog2(POINTS)
) (
  input  logic clk,
  input  logic rst,
  input  logic mem_we,
  input  logic [AW-1:0] mem_waddr,
  input  logic [31:0] mem_wdata,
  input  logic job_valid,
  input  dft_pkg::dft_job_t job,
  output logic job_pop,
  output logic m_valid,
  input  logic m_ready,
  output logic signed [23:0] m_re,
  output logic signed [23:0] m_im,
  output logic [5:0] m_idx,
  output logic m_last
);
  import dft_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_DONE = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  localparam int Stride = MaxPoints / POINTS;

  state_t state;
  logic [31:0] mem [POINTS];
  logic [31:0] rdata;
  logic [AW-1:0] k;
  logic [AW-1:0] j;
  logic [AW-1:0] m;
  logic [AW:0] cnt;
  logic inv;
  logic p_valid;
  logic signed [16:0] c_r;
  logic signed [16:0] s_r;
  logic signed [AccW-1:0] acc_re;
  logic signed [AccW-1:0] acc_im;
  logic signed [33:0] prr, pii, pri, pir;
  logic m_busy;
  logic [5:0] rom_m;
  logic signed [AccW-1:0] rr, ri;
  logic [2:0] sh;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[j];
  end

  assign rom_m = 6'(32'(m) * Stride);
  assign m_busy = m_valid && !m_ready;
  assign job_pop = (state == S_IDLE) && job_valid;
  assign sh = 3'(AW);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      p_valid <= 1'b0;
      m_valid <= 1'b0;
      k <= '0;
      j <= '0;
      m <= '0;
      cnt <= '0;
      inv <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        m_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            inv <= job.inverse;
            k <= '0;
            j <= '0;
            m <= '0;
            cnt <= '0;
            acc_re <= '0;
            acc_im <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          c_r <= rom_sin(rom_m + 6'd16);
          s_r <= inv ? rom_sin(rom_m) : -rom_sin(rom_m);
          p_valid <= (cnt < (AW+1)'(POINTS));
          if (cnt < (AW+1)'(POINTS)) begin
            j <= j + AW'(1);
            m <= m + k;
            cnt <= cnt + (AW+1)'(1);
          end else if (!p_valid) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_busy) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          m_valid <= 1'b1;
          m_re <= 24'(inv ? (rr >>> sh) : rr);
          m_im <= 24'(inv ? (ri >>> sh) : ri);
          m_idx <= 6'(k);
          m_last <= (k == AW'(POINTS - 1));
          acc_re <= '0;
          acc_im <= '0;
          j <= '0;
          m <= '0;
          cnt <= '0;
          k <= k + AW'(1);
          state <= (k == AW'(POINTS - 1)) ? S_IDLE : S_RUN;
        end
        default: state <= S_IDLE;
      endcase
      if (p_valid && state == S_RUN) begin
        acc_re <= acc_re + AccW'(prr) - AccW'(pii);
        acc_im <= acc_im + AccW'(pri) + AccW'(pir);
      end
    end
  end

  always_comb begin
    prr = $signed(rdata[15:0]) * c_r;
    pii = $signed(rdata[31:16]) * s_r;
    pri = $signed(rdata[15:0]) * s_r;
    pir = $signed(rdata[31:16]) * c_r;
    rr = (acc_re + AccW'(16384)) >>> 15;
    ri = (acc_im + AccW'(16384)) >>> 15;
  end

`include "dft_direct_forward_inverse_top_assert.svh"
  `DFT_ASSERT_IMP(a_hold, m_valid && !m_ready, state != S_OUT)
  `DFT_ASSERT_IMP(a_pop_idle, job_pop, state == S_IDLE)
  `DFT_ASSERT_NXT(a_last_idle, state == S_OUT && k == AW'(POINTS - 1), state == S_IDLE)
endmodule

@@ src/dft_direct_forward_inverse_top.sv @@
// Channel   Dir  Contents
// s_axis    in   tdata {sample_im, sample_re}
// m_axis    out  tdata {bin_index, bin_im, bin_re}, tlast last_bin
// cfg       in   inverse_mode write
// Each block of POINTS samples is stored at up to one beat per cycle.
// The back end then computes the bins one after another on a single
// complex MAC unit, summing all POINTS products of each bin.
// The input stalls from the last beat of a block until its last bin is accepted.
// Reset is synchronous; a bin waiting on m_axis holds the back end before the next bin.
module dft_direct_forward_inverse_top #(
  parameter int POINTS = dft_pkg::MaxPoints
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // sample_re, sample_im
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [55:0] m_axis_tdata,   // bin_re, bin_im, bin_index, zero pad
  output logic m_axis_tlast,
  input  logic cfg_we,
  input  logic cfg_wdata
);
  import dft_pkg::*;
  localparam int AW = $clog2(POINTS);

  logic inverse_mode;
  logic mem_we, job_push, job_pop, job_full;
  logic [AW-1:0] mem_addr;
  logic [31:0] mem_data;
  dft_job_t job_in, job_out;
  logic [1:0] qcnt;
  dft_job_t q;
  logic signed [23:0] re, im;
  logic [5:0] idx;
  logic busy_hold;
  logic bk_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_mode <= 1'b0;
    end else if (cfg_we) begin
      inverse_mode <= cfg_wdata;
    end
  end

  // The front end writes the store only after the back end has sent its last bin.
  assign job_full = (qcnt != 2'd0);
  assign job_out = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      qcnt <= '0;
    end else begin
      if (job_push) begin
        q <= job_in;
      end
      qcnt <= qcnt + 2'(job_push) - 2'(job_pop);
    end
  end

  dft_front #(.POINTS(POINTS), .AW(AW)) u_front (
    .clk, .rst,
    .s_valid(s_axis_tvalid), .s_ready(s_axis_tready), .s_data(s_axis_tdata),
    .inverse_mode, .mem_we, .mem_addr, .mem_data,
    .job_push, .job(job_in), .job_full(job_full || busy_hold)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bk_busy <= 1'b0;
    end else if (job_pop) begin
      bk_busy <= 1'b1;
    end else if (m_axis_tvalid && m_axis_tready && m_axis_tlast) begin
      bk_busy <= 1'b0;
    end
  end
  assign busy_hold = bk_busy;

  dft_back #(.POINTS(POINTS), .AW(AW)) u_back (
    .clk, .rst,
    .mem_we, .mem_waddr(mem_addr), .mem_wdata(mem_data),
    .job_valid(qcnt != 2'd0), .job(job_out), .job_pop,
    .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
    .m_re(re), .m_im(im), .m_idx(idx), .m_last(m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, idx, im, re};
endmodule

@@ tb/sv/tb.sv @@
module tb;
  localparam int Points = dft_pkg::MaxPoints;
  localparam int LogPoints = $clog2(Points);

  class bin_scoreboard;
    logic [31:0] block_samples[$];
    logic [55:0] pending_bins[$];
    logic pending_last[$];
    int errors;
    int bins_seen;

    function void note_sample(logic [31:0] beat, logic inverse);
      block_samples.push_back(beat);
      if (block_samples.size() == Points) begin
        compute_bins(inverse);
        block_samples.delete();
      end
    endfunction

    function void compute_bins(logic inverse);
      longint sum_re;
      longint sum_im;
      longint c;
      longint s;
      longint xr;
      longint xi;
      longint re;
      longint im;
      int m;
      logic [23:0] re24;
      logic [23:0] im24;
      logic [5:0] idx;
      for (int k = 0; k < Points; k++) begin
        sum_re = 0;
        sum_im = 0;
        for (int j = 0; j < Points; j++) begin
          xr = longint'($signed(block_samples[j][15:0]));
          xi = longint'($signed(block_samples[j][31:16]));
          m = ((k * j) % Points) * (64 / Points);
          c = sine_entry((m + 16) % 64);
          s = inverse ? sine_entry(m) : -sine_entry(m);
          sum_re += xr * c - xi * s;
          sum_im += xr * s + xi * c;
        end
        re = (sum_re + 16384) >>> 15;
        im = (sum_im + 16384) >>> 15;
        if (inverse) begin
          re = re >>> LogPoints;
          im = im >>> LogPoints;
        end
        re24 = re[23:0];
        im24 = im[23:0];
        idx = k[5:0];
        pending_bins.push_back({idx, im24, re24});
        pending_last.push_back(k == Points - 1);
      end
    endfunction

    function longint sine_entry(int m);
      int quarter[17] = '{0, 3212, 6393, 9512, 12540, 15447, 18205, 20788, 23170,
                          25330, 27246, 28899, 30274, 31357, 32138, 32610, 32767};
      int r;
      r = m % 16;
      case (m / 16)
        0: return quarter[r];
        1: return quarter[16 - r];
        2: return -quarter[r];
        default: return -quarter[16 - r];
      endcase
    endfunction

    function void check_bin(logic [55:0] data, logic last);
      logic [55:0] want;
      logic want_last;
      bins_seen++;
      if (pending_bins.size() == 0) begin
        $display("%0t: unexpected bin %h last %b", $time, data, last);
        errors++;
        return;
      end
      want = pending_bins.pop_front();
      want_last = pending_last.pop_front();
      if (data[23:0] !== want[23:0]) begin
        $display("%0t: bin_re expected %h actual %h", $time, want[23:0], data[23:0]);
        errors++;
      end
      if (data[47:24] !== want[47:24]) begin
        $display("%0t: bin_im expected %h actual %h", $time, want[47:24], data[47:24]);
        errors++;
      end
      if (data[53:48] !== want[53:48]) begin
        $display("%0t: bin_index expected %0d actual %0d", $time, want[53:48],
                 data[53:48]);
        errors++;
      end
      if (data[55:54] !== 2'b00) begin
        $display("%0t: pad expected 0 actual %b", $time, data[55:54]);
        errors++;
      end
      if (last !== want_last) begin
        $display("%0t: tlast expected %b actual %b", $time, want_last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  bin_scoreboard board = new();
  logic inverse_now = 1'b0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int blocks_done = 0;

  always #4 clk = ~clk;

  dft_direct_forward_inverse_top #(.POINTS(Points)) u_top (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      board.note_sample(s_axis_tdata, inverse_now);
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      board.check_bin(m_axis_tdata, m_axis_tlast);
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_sample(logic [15:0] re, logic [15:0] im);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {im, re};
    @(posedge clk);
    while (!s_axis_tready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic drain_and_set_mode(logic inverse);
    s_axis_tvalid <= 1'b0;
    while (board.pending_bins.size() != 0) begin
      @(negedge clk);
    end
    repeat (20) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= inverse;
    @(negedge clk);
    cfg_we <= 1'b0;
    inverse_now = inverse;
  endtask

  function automatic logic [15:0] random_value(int shape);
    case (shape)
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(7));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random_block(int shape);
    for (int j = 0; j < Points; j++) begin
      send_sample(random_value($urandom_range(3) == 0 ? $urandom_range(2) : shape),
                  random_value($urandom_range(3) == 0 ? $urandom_range(2) : shape));
    end
    blocks_done++;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    drain_and_set_mode(1'b0);
    for (int j = 0; j < Points; j++) begin
      send_sample(j == 0 ? 16'h7fff : (j[0] ? 16'h8000 : 16'h7fff),
                  j < 8 ? 16'h8000 : 16'h0000);
    end
    blocks_done++;
    drain_and_set_mode(1'b1);
    for (int j = 0; j < Points; j++) begin
      send_sample(16'h8000, 16'h8000);
    end
    blocks_done++;
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = (p % 4 == 1) ? 60 : (p % 4 == 3) ? 20 : 0;
      recv_stall_pct = (p % 4 == 2) ? 60 : (p % 4 == 3) ? 20 : 0;
      if (p % 2 == 1) begin
        drain_and_set_mode(1'($urandom_range(1)));
      end
      send_random_block(3);
      if (p == 2) begin
        for (int j = 0; j < Points / 2; j++) begin
          send_sample(16'($urandom), 16'($urandom));
        end
        drain_and_set_mode(~inverse_now);
        for (int j = 0; j < Points / 2; j++) begin
          send_sample(16'($urandom), 16'($urandom));
        end
        blocks_done++;
      end
    end
    s_axis_tvalid <= 1'b0;
    while (board.pending_bins.size() != 0) begin
      @(negedge clk);
    end
    repeat (200) @(negedge clk);
    $display("Sent %0d blocks of %0d samples, forward and inverse, with idle and stall phases.",
             blocks_done, Points);
    $display("Checked %0d bins, %0d mismatches.", board.bins_seen, board.errors);
    if (board.errors == 0 && board.pending_bins.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Timeout with %0d bins outstanding.", board.pending_bins.size());
    $display("status: fail");
    $finish;
  end
endmodule
